// ----- hdl/sfu_pkg.sv -----
package sfu_pkg;

  localparam int unsigned MaxFields  = 16;
  localparam int unsigned IdxW       = (MaxFields > 1) ? $clog2(MaxFields) : 1;
  localparam int unsigned TotW       = $clog2(MaxFields + 1);
  localparam int unsigned CountW     = 25;
  localparam int unsigned WideW      = 28;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [WideW-1:0] ByteCap = WideW'(16 * 1024 * 1024);

  localparam logic [7:0] ChBig    = 8'h3E;  // '>'
  localparam logic [7:0] ChNet    = 8'h21;  // '!'
  localparam logic [7:0] ChLittle = 8'h3C;  // '<'
  localparam logic [7:0] ChNative = 8'h3D;  // '='
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'

  typedef enum logic [3:0] {
    TY_I8, TY_U8, TY_I16, TY_U16, TY_I32, TY_U32, TY_I64, TY_U64, TY_F32, TY_F64, TY_PAD
  } type_e;

  typedef enum logic [2:0] {
    ST_VALUE, ST_END_OK, ST_COUNT_BIG, ST_FIELD_BIG,
    ST_BAD_CHAR, ST_INCOMPLETE, ST_DATA_SHORT, ST_TABLE_FULL
  } status_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] symbol;
    logic       final_req;
  } in_item_t;

  typedef struct packed {
    logic [63:0] field_bits;
    logic        is_float;
    status_e     status;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [3:0]        ty;
    logic [CountW-1:0] count;
  } tbl_wr_t;

  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Map a format character onto a field type; ok drops low for anything else.
  function automatic logic decode_type(input logic [7:0] c, output type_e ty);
    logic ok;
    ok = 1'b1;
    ty = TY_PAD;
    case (c)
      "b":     ty = TY_I8;
      "B":     ty = TY_U8;
      "h":     ty = TY_I16;
      "H":     ty = TY_U16;
      "i":     ty = TY_I32;
      "I":     ty = TY_U32;
      "q":     ty = TY_I64;
      "Q":     ty = TY_U64;
      "f":     ty = TY_F32;
      "d":     ty = TY_F64;
      "x":     ty = TY_PAD;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Log2 of the field size in bytes.
  function automatic logic [1:0] size_shift(input type_e ty);
    logic [1:0] s;
    case (ty)
      TY_I16, TY_U16:         s = 2'd1;
      TY_I32, TY_U32, TY_F32: s = 2'd2;
      TY_I64, TY_U64, TY_F64: s = 2'd3;
      default:                s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_signed(input type_e ty);
    return (ty == TY_I8) || (ty == TY_I16) || (ty == TY_I32) || (ty == TY_I64);
  endfunction

  // Exact float32 to float64 widening; subnormals are normalized.
  function automatic logic [63:0] widen_f32(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  top;
    logic [4:0]  lz;
    logic [51:0] frac;
    logic [10:0] ex;
    logic [51:0] mfull;
    e     = w[30:23];
    m     = w[22:0];
    mfull = {m, 29'b0};
    top   = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) top = 5'(i);
    end
    lz = 5'd22 - top;
    if (e == 8'hFF) begin
      ex   = 11'h7FF;
      frac = (m != '0) ? (mfull | {1'b1, 51'b0}) : '0;
    end else if (e == 8'h00) begin
      if (m == '0) begin
        ex   = '0;
        frac = '0;
      end else begin
        ex   = 11'd896 - 11'(lz);
        frac = mfull << (lz + 5'd1);
      end
    end else begin
      ex   = 11'(e) + 11'd896;
      frac = mfull;
    end
    return {w[31], ex, frac};
  endfunction

endpackage

// ----- hdl/sfu_table.sv -----
module sfu_table (
  input  logic                      clk_i,
  input  sfu_pkg::tbl_wr_t          wr_i,
  input  logic [sfu_pkg::IdxW-1:0]  rd_idx_i,
  output logic [3:0]                rd_type_o,
  output logic [sfu_pkg::CountW-1:0] rd_count_o
);
  import sfu_pkg::*;

  logic [3:0]        type_q  [MaxFields];
  logic [CountW-1:0] count_q [MaxFields];

  // Entries are only read below the stored total, so no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      type_q[wr_i.idx]  <= wr_i.ty;
      count_q[wr_i.idx] <= wr_i.count;
    end
  end

  assign rd_type_o  = type_q[rd_idx_i];
  assign rd_count_o = count_q[rd_idx_i];

endmodule

// ----- hdl/sfu_core.sv -----
module sfu_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  sfu_pkg::in_item_t item_i,
  output sfu_pkg::push_t    push_o
);
  import sfu_pkg::*;

  logic [TotW-1:0]   entry_total_q, entry_total_d;
  logic              big_order_q, big_order_d;
  logic [CountW-1:0] count_accum_q, count_accum_d;
  logic              at_start_q, at_start_d;
  logic [2:0]        ferr_q, ferr_d;
  logic [TotW-1:0]   cur_entry_q, cur_entry_d;
  logic [CountW-1:0] rep_done_q, rep_done_d;
  logic [2:0]        byte_pos_q, byte_pos_d;
  logic [63:0]       asm_q, asm_d;
  logic              digit_pend_q, digit_pend_d;

  tbl_wr_t           tbl_wr;
  logic              reload;
  logic [IdxW-1:0]   rd_idx;
  logic [3:0]        rd_type;
  logic [CountW-1:0] rd_count;

  // A data byte that closes an open format restarts the cursor at entry zero.
  assign reload = item_i.operation && !at_start_q;
  assign rd_idx = reload ? '0 : cur_entry_q[IdxW-1:0];

  sfu_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_idx_i  (rd_idx),
    .rd_type_o (rd_type),
    .rd_count_o(rd_count)
  );

  always_comb begin
    logic [WideW-1:0] acc_x10;
    logic [WideW-1:0] cnt_scaled;
    logic [CountW-1:0] cnt;
    type_e            ty;
    logic             ty_ok;
    logic             handled;
    logic [1:0]       shift;
    logic [2:0]       size_m1;
    logic [TotW-1:0]  cur_v;
    logic [CountW-1:0] rep_v;
    logic [2:0]       pos_v;
    logic [63:0]      asm_v;
    logic [63:0]      asm_new;
    logic [63:0]      raw;
    logic             sg;
    logic             emit;
    out_item_t        field_r;
    out_item_t        stat_r;

    entry_total_d = entry_total_q;
    big_order_d   = big_order_q;
    count_accum_d = count_accum_q;
    at_start_d    = at_start_q;
    ferr_d        = ferr_q;
    cur_entry_d   = cur_entry_q;
    rep_done_d    = rep_done_q;
    byte_pos_d    = byte_pos_q;
    asm_d         = asm_q;
    digit_pend_d  = digit_pend_q;
    tbl_wr        = '0;
    push_o        = '0;

    acc_x10    = '0;
    cnt_scaled = '0;
    cnt        = '0;
    ty         = TY_PAD;
    ty_ok      = 1'b0;
    handled    = 1'b0;
    shift      = '0;
    size_m1    = '0;
    cur_v      = cur_entry_q;
    rep_v      = rep_done_q;
    pos_v      = byte_pos_q;
    asm_v      = asm_q;
    asm_new    = '0;
    raw        = '0;
    sg         = 1'b0;
    emit       = 1'b0;
    field_r    = '0;
    stat_r     = '0;

    if (fire_i && !item_i.operation) begin
      // Format character.
      if (at_start_q) begin
        entry_total_d = '0;
        ferr_d        = ST_VALUE;
        count_accum_d = '0;
        digit_pend_d  = 1'b0;
        big_order_d   = 1'b1;
        if (item_i.symbol == ChBig || item_i.symbol == ChNet ||
            item_i.symbol == ChLittle || item_i.symbol == ChNative) begin
          big_order_d = (item_i.symbol == ChBig) || (item_i.symbol == ChNet);
          handled     = 1'b1;
        end
      end
      if (!handled && ferr_d == ST_VALUE) begin
        if (item_i.symbol >= ChZero && item_i.symbol <= ChNine) begin
          acc_x10 = (WideW'(count_accum_d) << 3) + (WideW'(count_accum_d) << 1)
                  + WideW'(item_i.symbol - ChZero);
          if (acc_x10 > ByteCap) begin
            ferr_d = ST_COUNT_BIG;
          end else begin
            count_accum_d = acc_x10[CountW-1:0];
            digit_pend_d  = 1'b1;
          end
        end else begin
          ty_ok = decode_type(item_i.symbol, ty);
          if (!ty_ok) begin
            ferr_d = ST_BAD_CHAR;
          end else begin
            cnt        = (count_accum_d != '0) ? count_accum_d : CountW'(1);
            cnt_scaled = WideW'(cnt) << size_shift(ty);
            if (cnt_scaled > ByteCap) begin
              ferr_d = ST_FIELD_BIG;
            end else if (entry_total_d >= TotW'(MaxFields)) begin
              ferr_d = ST_TABLE_FULL;
            end else begin
              tbl_wr.en     = 1'b1;
              tbl_wr.idx    = entry_total_d[IdxW-1:0];
              tbl_wr.ty     = ty;
              tbl_wr.count  = cnt;
              entry_total_d = entry_total_d + TotW'(1);
            end
            count_accum_d = '0;
            digit_pend_d  = 1'b0;
          end
        end
      end
      at_start_d = item_i.final_req;
      if (item_i.final_req) begin
        if (ferr_d == ST_VALUE && digit_pend_d) ferr_d = ST_INCOMPLETE;
        count_accum_d = '0;
        digit_pend_d  = 1'b0;
        cur_entry_d   = '0;
        rep_done_d    = '0;
        byte_pos_d    = '0;
        asm_d         = '0;
      end
    end else if (fire_i) begin
      // Data byte; close a format still open.
      if (reload) begin
        if (ferr_d == ST_VALUE) ferr_d = ST_INCOMPLETE;
        count_accum_d = '0;
        digit_pend_d  = 1'b0;
        at_start_d    = 1'b1;
        cur_v         = '0;
        rep_v         = '0;
        pos_v         = '0;
        asm_v         = '0;
      end
      cur_entry_d = cur_v;
      rep_done_d  = rep_v;
      byte_pos_d  = pos_v;
      asm_d       = asm_v;
      if (ferr_d == ST_VALUE && cur_v < entry_total_q) begin
        ty      = (rd_type > 4'(TY_PAD)) ? TY_PAD : type_e'(rd_type);
        shift   = size_shift(ty);
        size_m1 = 3'((4'd1 << shift) - 4'd1);
        sg      = is_signed(ty);
        if (big_order_q) asm_new = {asm_v[55:0], item_i.symbol};
        else             asm_new = asm_v | (64'(item_i.symbol) << {pos_v, 3'b000});
        if (pos_v >= size_m1) begin
          case (shift)
            2'd0:    raw = {{56{sg & asm_new[7]}},  asm_new[7:0]};
            2'd1:    raw = {{48{sg & asm_new[15]}}, asm_new[15:0]};
            2'd2:    raw = {{32{sg & asm_new[31]}}, asm_new[31:0]};
            default: raw = asm_new;
          endcase
          emit               = (ty != TY_PAD);
          field_r.is_float   = (ty == TY_F32) || (ty == TY_F64);
          field_r.field_bits = (ty == TY_F32) ? widen_f32(raw[31:0]) : raw;
          field_r.status     = ST_VALUE;
          field_r.run_end    = 1'b0;
          byte_pos_d         = '0;
          asm_d              = '0;
          if ((CountW+1)'(rep_v) + (CountW+1)'(1) >= (CountW+1)'(rd_count)) begin
            cur_entry_d = cur_v + TotW'(1);
            rep_done_d  = '0;
          end else begin
            rep_done_d = rep_v + CountW'(1);
          end
        end else begin
          byte_pos_d = pos_v + 3'd1;
          asm_d      = asm_new;
        end
      end
      if (item_i.final_req) begin
        stat_r.run_end = 1'b1;
        if (ferr_d != ST_VALUE) stat_r.status = status_e'(ferr_d);
        else if (cur_entry_d >= entry_total_q) stat_r.status = ST_END_OK;
        else stat_r.status = ST_DATA_SHORT;
        cur_entry_d = '0;
        rep_done_d  = '0;
        byte_pos_d  = '0;
        asm_d       = '0;
      end
      if (emit && item_i.final_req) begin
        push_o.num    = 2'd2;
        push_o.first  = field_r;
        push_o.second = stat_r;
      end else if (emit) begin
        push_o.num   = 2'd1;
        push_o.first = field_r;
      end else if (item_i.final_req) begin
        push_o.num   = 2'd1;
        push_o.first = stat_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_total_q <= '0;
      big_order_q   <= 1'b1;
      count_accum_q <= '0;
      at_start_q    <= 1'b1;
      ferr_q        <= ST_VALUE;
      cur_entry_q   <= '0;
      rep_done_q    <= '0;
      byte_pos_q    <= '0;
      asm_q         <= '0;
      digit_pend_q  <= 1'b0;
    end else begin
      entry_total_q <= entry_total_d;
      big_order_q   <= big_order_d;
      count_accum_q <= count_accum_d;
      at_start_q    <= at_start_d;
      ferr_q        <= ferr_d;
      cur_entry_q   <= cur_entry_d;
      rep_done_q    <= rep_done_d;
      byte_pos_q    <= byte_pos_d;
      asm_q         <= asm_d;
      digit_pend_q  <= digit_pend_d;
    end
  end

endmodule

// ----- hdl/sfu_out_fifo.sv -----
module sfu_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfu_pkg::push_t     push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfu_pkg::out_item_t out_item_o
);
  import sfu_pkg::*;

  out_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rptr_q];
  // Room for the worst case of two results from one transfer.
  assign room_o      = (cnt_q <= QCntW'(QueueDepth - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wptr_d = wptr_q + QPtrW'(push_i.num);
    rptr_d = rptr_q + QPtrW'(pop);
    cnt_d  = cnt_q + QCntW'(push_i.num) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wptr_q] <= push_i.first;
    if (push_i.num == 2'd2) mem_q[wptr_q + QPtrW'(1)] <= push_i.second;
  end

endmodule

// ----- hdl/struct_format_unpacker_top.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   in_item_i  (operation, symbol, final_req)
// result    out        out_valid_o / out_stall_i out_item_o (field_bits, is_float, status,
//                                                            run_end)
//
// One transfer per cycle is taken while the result queue has room: a transfer
// lands in the input register, is parsed or assembled once the queue can take
// its worst case, and its results (up to two) are written into the four-entry
// result queue, whose head drives the output. Reset clears all control state;
// the field table comes out of reset unwritten and is only read below the stored
// entry count. A stall at the output backs up into the queue, and in_stall_o
// rises once the queue can no longer take two more results.
module struct_format_unpacker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfu_pkg::out_item_t out_item_o
);
  import sfu_pkg::*;

  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;
  logic     fire;
  logic     room;
  logic     accept;
  push_t    push;

  // Advance the held item when the queue has room for its worst case.
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)    in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the payload until the next transfer replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
  end

  sfu_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_item_q),
    .push_o(push)
  );

  sfu_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- tb/sv/struct_format_unpacker_top_test.sv -----
`timescale 1ns / 1ps

module struct_format_unpacker_top_test;
  import sfu_pkg::*;

  localparam int unsigned ByteLimit  = 16 * 1024 * 1024;
  localparam int unsigned QuietLimit = 3000;  // cycles with no transfer on either side
  localparam int unsigned ItemGoal   = 450;
  localparam int unsigned TailCycles = 8;     // settling time after the last drain
  localparam int unsigned ShortData  = 48;    // longest data run worth sending in full

  // Index of each character is its type code.
  localparam string TypeChars = "bBhHiIqQfdx";

  typedef struct {
    in_item_t  stim;
    bit        typed;  // 1: compare against want, not the predictor
    out_item_t want;
  } drill_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  struct_format_unpacker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Predictor copy of the parser and assembler state.
  type_e       tbl_type  [MaxFields];
  int unsigned tbl_count [MaxFields];
  int unsigned tbl_used;
  bit          big_end;
  int unsigned count_acc;
  bit          digits_open;
  bit          fmt_fresh;    // next format character opens a new format
  status_e     fmt_err;      // ST_VALUE while no format error is held
  int unsigned field_idx;
  int unsigned reps_left;
  int unsigned byte_idx;
  logic [63:0] acc;

  out_item_t   fresh[$];     // results of the transfer just modeled
  out_item_t   field_q[$];   // results still owed by the block

  logic [7:0]  order_marks [4] = '{ChBig, ChNet, ChLittle, ChNative};

  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned fed;          // transfers that the block acted on
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] ty_char(input type_e t);
    return TypeChars[t];
  endfunction

  function automatic int char_to_type(input logic [7:0] c);
    for (int i = 0; i < TypeChars.len(); i++) begin
      if (TypeChars[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic int unsigned type_bytes(input type_e t);
    case (t)
      TY_I16, TY_U16:         return 2;
      TY_I32, TY_U32, TY_F32: return 4;
      TY_I64, TY_U64, TY_F64: return 8;
      default:                return 1;
    endcase
  endfunction

  function automatic out_item_t pack_result(input logic [63:0] bits, input logic flt,
                                            input status_e st, input logic last);
    out_item_t r;
    r.field_bits = bits;
    r.is_float   = flt;
    r.status     = st;
    r.run_end    = last;
    return r;
  endfunction

  function automatic in_item_t fmt_item(input logic [7:0] c);
    in_item_t it;
    it.operation = 1'b0;
    it.symbol    = c;
    it.final_req = 1'b0;
    return it;
  endfunction

  function automatic in_item_t data_item(input logic [7:0] b, input bit fin);
    in_item_t it;
    it.operation = 1'b1;
    it.symbol    = b;
    it.final_req = fin;
    return it;
  endfunction

  function automatic drill_row_t drill_row(input logic op, input logic [7:0] sym,
                                           input logic fin, input bit typed = 1'b0,
                                           input out_item_t want = '0);
    drill_row_t r;
    r.stim.operation = op;
    r.stim.symbol    = sym;
    r.stim.final_req = fin;
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  // Exact float32 to float64 widening: NaN payload moves up with the quiet bit set,
  // subnormals are renormalized.
  function automatic logic [63:0] f32_to_f64(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [51:0] frac;
    logic [63:0] shifted;
    int          p;
    ex   = w[30:23];
    man  = w[22:0];
    frac = {man, 29'b0};
    if (ex == 8'hFF) begin
      if (man != '0) frac[51] = 1'b1;
      return {w[31], 11'h7FF, frac};
    end
    if (ex == 8'h00) begin
      if (man == '0) return {w[31], 63'b0};
      p = 22;
      while (!man[p]) p--;
      shifted = 64'(man) << (52 - p);
      return {w[31], 11'(p + 874), shifted[51:0]};
    end
    return {w[31], 11'(ex) + 11'd896, frac};
  endfunction

  function automatic void clear_model();
    tbl_used    = 0;
    big_end     = 1'b1;
    count_acc   = 0;
    digits_open = 1'b0;
    fmt_fresh   = 1'b1;
    fmt_err     = ST_VALUE;
    field_idx   = 0;
    reps_left   = 0;
    byte_idx    = 0;
    acc         = '0;
  endfunction

  function automatic void rewind_fields();
    field_idx = 0;
    byte_idx  = 0;
    acc       = '0;
    reps_left = (tbl_used > 0) ? tbl_count[0] : 0;
  endfunction

  function automatic void close_format();
    count_acc   = 0;
    digits_open = 1'b0;
    fmt_fresh   = 1'b1;
    rewind_fields();
  endfunction

  function automatic void parse_char(input logic [7:0] c, input bit fin);
    bit          took_mark;
    int          t;
    int unsigned n;
    int unsigned reps;
    took_mark = 1'b0;
    if (fmt_fresh) begin
      tbl_used    = 0;
      fmt_err     = ST_VALUE;
      count_acc   = 0;
      digits_open = 1'b0;
      big_end     = 1'b1;
      fmt_fresh   = 1'b0;
      if (c inside {ChBig, ChNet, ChLittle, ChNative}) begin
        big_end   = (c == ChBig) || (c == ChNet);
        took_mark = 1'b1;
      end
    end
    if (!took_mark && fmt_err == ST_VALUE) begin
      if (c >= ChZero && c <= ChNine) begin
        n = count_acc * 10 + (c - ChZero);
        if (n > ByteLimit) begin
          fmt_err = ST_COUNT_BIG;
        end else begin
          count_acc   = n;
          digits_open = 1'b1;
        end
      end else begin
        t = char_to_type(c);
        if (t < 0) begin
          fmt_err = ST_BAD_CHAR;
        end else begin
          reps = (count_acc != 0) ? count_acc : 1;
          if (reps * type_bytes(type_e'(t)) > ByteLimit) begin
            fmt_err = ST_FIELD_BIG;
          end else if (tbl_used >= MaxFields) begin
            fmt_err = ST_TABLE_FULL;
          end else begin
            tbl_type[tbl_used]  = type_e'(t);
            tbl_count[tbl_used] = reps;
            tbl_used++;
          end
          count_acc   = 0;
          digits_open = 1'b0;
        end
      end
    end
    if (fin) begin
      if (fmt_err == ST_VALUE && digits_open) fmt_err = ST_INCOMPLETE;
      close_format();
    end
  endfunction

  // Advance the predictor by one transfer, leave its results in fresh, and
  // return whether the block acts on it at all.
  function automatic bit step_model(input in_item_t it);
    type_e       t;
    int unsigned sz;
    logic [63:0] raw;
    bit          counted;
    status_e     st;
    if (!it.operation) begin
      counted = fmt_fresh || (fmt_err == ST_VALUE) || it.final_req;
      parse_char(it.symbol, it.final_req);
      return counted;
    end
    // Data before the closing format character ends the format unfinished.
    if (!fmt_fresh) begin
      if (fmt_err == ST_VALUE) fmt_err = ST_INCOMPLETE;
      close_format();
    end
    counted = it.final_req;
    if (fmt_err == ST_VALUE && field_idx < tbl_used) begin
      counted = 1'b1;
      t  = tbl_type[field_idx];
      sz = type_bytes(t);
      if (big_end) acc = {acc[55:0], it.symbol};
      else acc[8*byte_idx +: 8] = it.symbol;
      if (byte_idx + 1 >= sz) begin
        raw = acc;
        if (sz < 8) begin
          raw = raw & ((64'd1 << (8 * sz)) - 64'd1);
          if ((t inside {TY_I8, TY_I16, TY_I32}) && raw[8*sz-1]) raw = raw | (~64'd0 << (8 * sz));
        end
        case (t)
          TY_F32:  fresh = {fresh, pack_result(f32_to_f64(raw[31:0]), 1'b1, ST_VALUE, 1'b0)};
          TY_F64:  fresh = {fresh, pack_result(raw, 1'b1, ST_VALUE, 1'b0)};
          TY_PAD:  ;
          default: fresh = {fresh, pack_result(raw, 1'b0, ST_VALUE, 1'b0)};
        endcase
        byte_idx = 0;
        acc      = '0;
        if (reps_left > 0) reps_left--;
        if (reps_left == 0) begin
          field_idx++;
          if (field_idx < tbl_used) reps_left = tbl_count[field_idx];
        end
      end else begin
        byte_idx++;
      end
    end
    if (it.final_req) begin
      if (fmt_err != ST_VALUE) st = fmt_err;
      else st = (field_idx >= tbl_used) ? ST_END_OK : ST_DATA_SHORT;
      fresh = {fresh, pack_result('0, 1'b0, st, 1'b1)};
      rewind_fields();
    end
    return counted;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // Present one transfer, hold it through stalls, and book its results once taken.
  // Random gaps go in front of it; valid stays high afterwards until the next call
  // or a hold-off lowers it at a falling edge.
  task automatic send_symbol(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t want = '0);
    bit taken;
    taken = 1'b0;
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    while (!taken) begin
      @(posedge clk_i);
      if (!in_stall_o) taken = 1'b1;
      else @(negedge clk_i);
    end
    fresh.delete();
    if (step_model(it)) fed++;
    if (typed) begin
      field_q = {field_q, want};
    end else begin
      foreach (fresh[k]) field_q = {field_q, fresh[k]};
    end
  endtask

  // Drop valid and hold the sender until every owed result has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed formats with random types and counts; now and then a huge
  // count, a full table, a stray character, a late order mark, a dangling count
  // or a format left open.
  task automatic send_format_run();
    in_item_t burst[$];
    int       entries;
    int       tsel;
    int       reps;
    string    digits;
    entries = ($urandom_range(99) < 5) ? MaxFields + 1 : $urandom_range(0, 4);
    if ($urandom_range(99) < 25) burst = {burst, fmt_item(order_marks[$urandom_range(3)])};
    for (int e = 0; e < entries; e++) begin
      tsel = $urandom_range(TypeChars.len() - 1);
      case ($urandom_range(19))
        0:             reps = $urandom_range(99999999, ByteLimit + 1);
        1:             reps = ByteLimit / type_bytes(type_e'(tsel)) + $urandom_range(1);
        2, 3, 4, 5, 6: reps = -1;
        7:             reps = 0;
        default:       reps = $urandom_range(1, 4);
      endcase
      if (reps >= 0) begin
        digits = $sformatf("%0d", reps);
        for (int k = 0; k < digits.len(); k++) burst = {burst, fmt_item(digits[k])};
      end
      burst = {burst, fmt_item(TypeChars[tsel])};
    end
    case ($urandom_range(24))
      0: burst.insert($urandom_range(burst.size()), fmt_item(8'($urandom_range(255))));
      1: burst = {burst, fmt_item(order_marks[$urandom_range(3)])};
      2: burst = {burst, fmt_item(8'(ChZero + $urandom_range(9)))};
      default: ;
    endcase
    if (burst.size() == 0) burst = {burst, fmt_item(order_marks[$urandom_range(3)])};
    burst[burst.size() - 1].final_req = ($urandom_range(19) != 0);
    foreach (burst[k]) send_symbol(burst[k]);
  endtask

  // Size the data run from the table just stored: mostly exact, sometimes short
  // or with bytes to spare; special float bytes are favored.
  task automatic send_data_run();
    longint unsigned need;
    int unsigned     len;
    logic [7:0]      hot [4];
    logic [7:0]      b;
    hot = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    need = 0;
    for (int e = 0; e < tbl_used; e++) need += longint'(tbl_count[e]) * type_bytes(tbl_type[e]);
    if (fmt_err != ST_VALUE || !fmt_fresh) begin
      len = $urandom_range(1, 4);
    end else if (need > ShortData) begin
      len = $urandom_range(1, 24);
    end else begin
      case ($urandom_range(9))
        0:       len = (need > 1) ? $urandom_range(1, int'(need) - 1) : 1;
        1:       len = int'(need) + $urandom_range(1, 3);
        default: len = (need == 0) ? 1 : int'(need);
      endcase
    end
    for (int k = 0; k < len; k++) begin
      b = ($urandom_range(3) == 0) ? hot[$urandom_range(3)] : 8'($urandom_range(255));
      send_symbol(data_item(b, k == len - 1));
    end
  endtask

  // Result side: stall at random, compare every transfer with the oldest owed result.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (field_q.size() == 0) begin
        report_mismatch($sformatf("result %h with none owed", out_item_o));
      end else begin
        want = field_q.pop_front();
        check_field("field_bits", out_item_o.field_bits, want.field_bits);
        check_field("is_float", 64'(out_item_o.is_float), 64'(want.is_float));
        check_field("status", 64'(out_item_o.status), 64'(want.status));
        check_field("run_end", 64'(out_item_o.run_end), 64'(want.run_end));
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    drill_row_t drill[$];
    int         stage;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    rst_ni         = 1'b0;
    mismatch_cnt   = 0;
    quiet_cycles   = 0;
    fed            = 0;
    src_gap_pct    = 27;
    sink_stall_pct = 77;
    stage          = 0;
    clear_model();

    // Directed rows: operation, symbol, final, then the typed result where obvious.
    drill = '{
      // data with no format stored yet: empty table, run ends cleanly
      drill_row(1'b1, 8'h00, 1'b1, 1'b1, pack_result('0, 1'b0, ST_END_OK, 1'b1)),
      // default big order: b B H
      drill_row(1'b0, ty_char(TY_I8), 1'b0),
      drill_row(1'b0, ty_char(TY_U8), 1'b0),
      drill_row(1'b0, ty_char(TY_U16), 1'b1),
      drill_row(1'b1, 8'h80, 1'b0, 1'b1,
                pack_result(64'hFFFF_FFFF_FFFF_FF80, 1'b0, ST_VALUE, 1'b0)),
      drill_row(1'b1, 8'hFF, 1'b0, 1'b1, pack_result(64'h0000_0000_0000_00FF, 1'b0,
                                                     ST_VALUE, 1'b0)),
      drill_row(1'b1, 8'h12, 1'b0),
      drill_row(1'b1, 8'h34, 1'b1),
      // little order, float32 negative infinity
      drill_row(1'b0, ChNative, 1'b0),
      drill_row(1'b0, ty_char(TY_F32), 1'b1),
      drill_row(1'b1, 8'h00, 1'b0),
      drill_row(1'b1, 8'h00, 1'b0),
      drill_row(1'b1, 8'h80, 1'b0),
      drill_row(1'b1, 8'hFF, 1'b1),
      // order mark after the first character is a bad character
      drill_row(1'b0, ty_char(TY_I32), 1'b0),
      drill_row(1'b0, ChLittle, 1'b1),
      drill_row(1'b1, 8'h55, 1'b1, 1'b1, pack_result('0, 1'b0, ST_BAD_CHAR, 1'b1)),
      // count with no type behind it
      drill_row(1'b0, 8'(ChZero + 3), 1'b1),
      drill_row(1'b1, 8'h00, 1'b1, 1'b1, pack_result('0, 1'b0, ST_INCOMPLETE, 1'b1)),
      // data arrives while the format is still open
      drill_row(1'b0, ty_char(TY_F64), 1'b0),
      drill_row(1'b1, 8'h01, 1'b1, 1'b1, pack_result('0, 1'b0, ST_INCOMPLETE, 1'b1)),
      // one byte for an eight-byte field
      drill_row(1'b0, ty_char(TY_U64), 1'b1),
      drill_row(1'b1, 8'h01, 1'b1, 1'b1, pack_result('0, 1'b0, ST_DATA_SHORT, 1'b1))
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (drill[k]) send_symbol(drill[k].stim, drill[k].typed, drill[k].want);

    // Random runs in three idling phases; drain the block at each switch.
    while (fed < ItemGoal) begin
      if (stage == 0 && fed >= ItemGoal / 3) begin
        drain();
        src_gap_pct    = 77;
        sink_stall_pct = 27;
        stage          = 1;
      end else if (stage == 1 && fed >= 2 * ItemGoal / 3) begin
        drain();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        stage          = 2;
      end
      send_format_run();
      repeat ($urandom_range(1, 3)) send_data_run();
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
